// ----- hw/rtl/rbte_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbte_pkg
// Constants and helper functions for the BCD clock to epoch seconds converter.
// ----------------------------------------------------------------------------
package rbte_pkg;

    localparam int DayW   = 17;
    localparam int TodW   = 17;
    localparam int ProdW  = 34;
    localparam int SumW   = 35;
    localparam int EpochW = 32;

    localparam logic [DayW-1:0] Days2000     = 17'd11017;
    localparam logic [DayW-1:0] DaysMar1999  = 17'd10651;
    localparam logic [DayW-1:0] SecsPerDay   = 17'd86400;
    localparam logic [TodW-1:0] SecsPerHour  = 17'd3600;
    localparam logic [TodW-1:0] SecsPerMin   = 17'd60;
    localparam logic [DayW-1:0] DaysPerYear  = 17'd365;

    // Decodes two BCD digits without rejecting digits above nine.
    function automatic logic [7:0] bcd_value(input logic [7:0] b);
        bcd_value = 8'(b[7:4]) * 8'd10 + 8'(b[3:0]);
    endfunction

    // Days from March 1 to the first of the given month, in a March-based year.
    function automatic logic [8:0] month_offset(input logic [4:0] m);
        case (m)
            5'd1:    month_offset = 9'd306;
            5'd2:    month_offset = 9'd337;
            5'd3:    month_offset = 9'd0;
            5'd4:    month_offset = 9'd31;
            5'd5:    month_offset = 9'd61;
            5'd6:    month_offset = 9'd92;
            5'd7:    month_offset = 9'd122;
            5'd8:    month_offset = 9'd153;
            5'd9:    month_offset = 9'd184;
            5'd10:   month_offset = 9'd214;
            5'd11:   month_offset = 9'd245;
            5'd12:   month_offset = 9'd275;
            default: month_offset = 9'd0;
        endcase
    endfunction

endpackage

// ----- hw/rtl/rtc_bcd_regs_to_epoch_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_bcd_regs_to_epoch_core
// Converts one snapshot of BCD clock registers to Unix seconds with a flag.
// ----------------------------------------------------------------------------
// Channel | Handshake             | Payload
// in      | in_valid / in_ready   | seconds_reg minutes_reg hours_reg date_reg
//         |                       | month_reg year_reg
// out     | out_valid / out_ready | epoch_seconds valid_res
//
// Four register stages: decode and range check, day count and time of day,
// day multiply, final add and overflow check. One transaction enters per
// cycle unless the output is held. Reset clears the stage valid bits.
// When the output is held, all stages stall together and in_ready drops.
// ----------------------------------------------------------------------------
module rtc_bcd_regs_to_epoch_core
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 seconds_reg,
    input  logic [7:0]                 minutes_reg,
    input  logic [7:0]                 hours_reg,
    input  logic [7:0]                 date_reg,
    input  logic [7:0]                 month_reg,
    input  logic [7:0]                 year_reg,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [rbte_pkg::EpochW-1:0] epoch_seconds,
    output logic                       valid_res
);
    import rbte_pkg::*;

    logic advance;

    logic            s1_valid_reg, s1_valid_next;
    logic            s1_ok_reg, s1_ok_next;
    logic [6:0]      s1_sec_reg, s1_sec_next;
    logic [6:0]      s1_min_reg, s1_min_next;
    logic [4:0]      s1_hour_reg, s1_hour_next;
    logic [4:0]      s1_day_reg, s1_day_next;
    logic [8:0]      s1_mofs_reg, s1_mofs_next;
    logic [7:0]      s1_year_reg, s1_year_next;
    logic            s1_early_reg, s1_early_next;

    logic            s2_valid_reg, s2_valid_next;
    logic            s2_ok_reg, s2_ok_next;
    logic [DayW-1:0] s2_days_reg, s2_days_next;
    logic [TodW-1:0] s2_tod_reg, s2_tod_next;

    logic             s3_valid_reg, s3_valid_next;
    logic             s3_ok_reg, s3_ok_next;
    logic [ProdW-1:0] s3_prod_reg, s3_prod_next;
    logic [TodW-1:0]  s3_tod_reg, s3_tod_next;

    logic              out_valid_reg, out_valid_next;
    logic              res_ok_reg, res_ok_next;
    logic [EpochW-1:0] epoch_reg, epoch_next;

    logic [7:0] sec_v, min_v, h12_v, h24_v, day_v, mon_v, hour_v;
    logic       twelve_mode, h12_bad;
    logic [7:0] year_eff;
    logic [DayW-1:0] year_days;
    logic [SumW-1:0] total;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    always_comb
    begin
        sec_v       = bcd_value({1'b0, seconds_reg[6:0]});
        min_v       = bcd_value({1'b0, minutes_reg[6:0]});
        h12_v       = bcd_value({3'b000, hours_reg[4:0]});
        h24_v       = bcd_value({2'b00, hours_reg[5:0]});
        day_v       = bcd_value({2'b00, date_reg[5:0]});
        mon_v       = bcd_value({3'b000, month_reg[4:0]});
        twelve_mode = hours_reg[6];
        h12_bad     = (h12_v < 8'd1) || (h12_v > 8'd12);
        if (twelve_mode)
        begin
            hour_v = ((h12_v == 8'd12) ? 8'd0 : h12_v) + (hours_reg[5] ? 8'd12 : 8'd0);
        end
        else
        begin
            hour_v = h24_v;
        end

        s1_valid_next = in_valid;
        s1_ok_next    = !(twelve_mode && h12_bad) && (sec_v <= 8'd59) && (min_v <= 8'd59)
                        && (hour_v <= 8'd23) && (day_v >= 8'd1) && (day_v <= 8'd31)
                        && (mon_v >= 8'd1) && (mon_v <= 8'd12);
        s1_sec_next   = sec_v[6:0];
        s1_min_next   = min_v[6:0];
        s1_hour_next  = hour_v[4:0];
        s1_day_next   = day_v[4:0];
        s1_mofs_next  = month_offset(mon_v[4:0]);
        s1_year_next  = bcd_value(year_reg);
        s1_early_next = (mon_v <= 8'd2);
    end

    always_comb
    begin
        year_eff  = s1_year_reg - 8'(s1_early_reg);
        year_days = DayW'(year_eff) * DaysPerYear + DayW'(year_eff[7:2])
                    - ((year_eff >= 8'd100) ? DayW'(1) : DayW'(0));
        if (s1_early_reg && (s1_year_reg == 8'd0))
        begin
            s2_days_next = DaysMar1999 + DayW'(s1_mofs_reg) + DayW'(s1_day_reg) - DayW'(1);
        end
        else
        begin
            s2_days_next = Days2000 + year_days + DayW'(s1_mofs_reg)
                           + DayW'(s1_day_reg) - DayW'(1);
        end
        s2_tod_next   = TodW'(s1_hour_reg) * SecsPerHour + TodW'(s1_min_reg) * SecsPerMin
                        + TodW'(s1_sec_reg);
        s2_valid_next = s1_valid_reg;
        s2_ok_next    = s1_ok_reg;
    end

    always_comb
    begin
        s3_prod_next  = ProdW'(s2_days_reg) * ProdW'(SecsPerDay);
        s3_tod_next   = s2_tod_reg;
        s3_valid_next = s2_valid_reg;
        s3_ok_next    = s2_ok_reg;
    end

    always_comb
    begin
        total          = SumW'(s3_prod_reg) + SumW'(s3_tod_reg);
        res_ok_next    = s3_ok_reg && (total[SumW-1:EpochW] == '0);
        epoch_next     = res_ok_next ? total[EpochW-1:0] : '0;
        out_valid_next = s3_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_ok_reg    <= s1_ok_next;
            s1_sec_reg   <= s1_sec_next;
            s1_min_reg   <= s1_min_next;
            s1_hour_reg  <= s1_hour_next;
            s1_day_reg   <= s1_day_next;
            s1_mofs_reg  <= s1_mofs_next;
            s1_year_reg  <= s1_year_next;
            s1_early_reg <= s1_early_next;
            s2_ok_reg    <= s2_ok_next;
            s2_days_reg  <= s2_days_next;
            s2_tod_reg   <= s2_tod_next;
            s3_ok_reg    <= s3_ok_next;
            s3_prod_reg  <= s3_prod_next;
            s3_tod_reg   <= s3_tod_next;
            res_ok_reg   <= res_ok_next;
            epoch_reg    <= epoch_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign epoch_seconds = epoch_reg;
    assign valid_res     = res_ok_reg;

endmodule
